@@ rtl/core/ipr_pkg.sv @@
// Shared types, codes and constants of the address reputation verdict core.
// Used by ipr_front, ipr_queue, ipr_back and the core top; depends on nothing.
package ipr_pkg;

  localparam int NET_ENTRIES_DEF  = 16;
  localparam int ASN_ENTRIES_DEF  = 16;
  localparam int CODE_ENTRIES_DEF = 32;

  localparam int IN_TDATA_W  = 216;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NET_WORD_W  = 137;

  // Item kinds.
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Load targets.
  localparam logic [2:0] TS_ALLOW_NET  = 3'd0;
  localparam logic [2:0] TS_BLOCK_NET  = 3'd1;
  localparam logic [2:0] TS_ASN        = 3'd2;
  localparam logic [2:0] TS_FLAG_CODE  = 3'd3;
  localparam logic [2:0] TS_ALLOW_CODE = 3'd4;
  localparam logic [2:0] TS_BLOCK_CODE = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NET_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_NET_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASN_COUNT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_CODE_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_CODE_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CODE_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MASK        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_ENABLED      = 3'd7;

  // Verdicts and reasons.
  localparam logic [1:0] V_PASS      = 2'd0;
  localparam logic [1:0] V_FORBIDDEN = 2'd1;
  localparam logic [1:0] V_HIDDEN    = 2'd2;

  localparam logic [2:0] R_NONE      = 3'd0;
  localparam logic [2:0] R_ALLOWLIST = 3'd1;
  localparam logic [2:0] R_BLOCKLIST = 3'd2;
  localparam logic [2:0] R_NOT_WL    = 3'd3;
  localparam logic [2:0] R_FLAG      = 3'd4;
  localparam logic [2:0] R_ASN       = 3'd5;
  localparam logic [2:0] R_COUNTRY   = 3'd6;

  typedef struct packed {
    logic [4:0]  allow_net_count;
    logic [4:0]  block_net_count;
    logic [4:0]  asn_count;
    logic [5:0]  flag_code_count;
    logic [5:0]  allow_code_count;
    logic [5:0]  block_code_count;
    logic [15:0] deny_flags;
    logic        geo_enabled;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  prefix;
    logic        found;
    logic [15:0] cc;
    logic [15:0] nf;
    logic [31:0] asn;
    logic [2:0]  sel;
    logic [4:0]  idx;
  } item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [2:0]  reason_code;
    logic        geo_reached;
    logic [15:0] country_out;
    logic [15:0] flags_out;
    logic [31:0] asn_out;
  } res_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ rtl/core/ipr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; instantiated for the network, ASN and code tables.
module ipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/ipr_front.sv @@
// Front end: unpacks an input transfer and normalises the address of a check.
// Depends on ipr_pkg.
module ipr_front (
  input  logic [ipr_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output ipr_pkg::item_t                 item
);
  import ipr_pkg::*;

  logic        is_v6;
  logic [63:0] hi;
  logic [63:0] lo;
  logic        mapped;

  assign is_v6  = s_tdata[0];
  assign hi     = s_tdata[64:1];
  assign lo     = s_tdata[128:65];
  // An IPv4-mapped IPv6 address is handled as plain IPv4.
  assign mapped = (hi == 64'd0) && (lo[63:32] == 32'h0000_FFFF);

  always_comb begin
    item.op     = s_tuser;
    item.v6     = is_v6;
    item.hi     = hi;
    item.lo     = lo;
    item.prefix = s_tdata[136:129];
    item.found  = s_tdata[137];
    item.cc     = s_tdata[153:138];
    item.nf     = s_tdata[169:154];
    item.asn    = s_tdata[201:170];
    item.sel    = s_tdata[204:202];
    item.idx    = s_tdata[209:205];
    if (s_tuser == OP_CHECK) begin
      item.v6 = is_v6 && !mapped;
      if (!item.v6) begin
        item.lo = {32'd0, lo[31:0]};
      end
    end
  end
endmodule

@@ rtl/core/ipr_queue.sv @@
// Two-entry queue that decouples the front end from the table walker.
// Depends on ipr_pkg.
module ipr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ipr_pkg::item_t push_item,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output ipr_pkg::item_t head
);
  import ipr_pkg::*;

  item_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end
endmodule

@@ rtl/core/ipr_back.sv @@
// Back end: writes table entries and walks the lists in priority order with
// one comparator per table RAM, then registers the result. Depends on ipr_pkg
// and ipr_ram.
module ipr_back #(
  parameter int NET_ENTRIES  = ipr_pkg::NET_ENTRIES_DEF,
  parameter int ASN_ENTRIES  = ipr_pkg::ASN_ENTRIES_DEF,
  parameter int CODE_ENTRIES = ipr_pkg::CODE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ipr_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  ipr_pkg::item_t q_item,
  output logic           q_pop,
  output logic           res_valid,
  output ipr_pkg::res_t  res,
  input  logic           m_tready
);
  import ipr_pkg::*;

  localparam int NetDepth  = 2 * NET_ENTRIES;
  localparam int CodeDepth = 3 * CODE_ENTRIES;
  localparam int NAW = addr_w(NetDepth);
  localparam int AAW = addr_w(ASN_ENTRIES);
  localparam int CAW = addr_w(CodeDepth);
  localparam int MaxN = (NET_ENTRIES > ASN_ENTRIES)
                        ? ((NET_ENTRIES > CODE_ENTRIES) ? NET_ENTRIES : CODE_ENTRIES)
                        : ((ASN_ENTRIES > CODE_ENTRIES) ? ASN_ENTRIES : CODE_ENTRIES);
  localparam int CW = $clog2(MaxN + 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ALLOW = 8'b0000_0010,
    ST_BLOCK = 8'b0000_0100,
    ST_GEO   = 8'b0000_1000,
    ST_ASN   = 8'b0001_0000,
    ST_FLAG  = 8'b0010_0000,
    ST_ACODE = 8'b0100_0000,
    ST_BCODE = 8'b1000_0000
  } state_t;

  state_t  state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic    cmpv, cmpv_next;
  item_t   cur;
  res_t    res_next;
  logic    res_load;

  logic [CW-1:0] n_allow, n_block, n_asn, n_flag, n_ac, n_bc, walk_cnt;
  logic    walk_hit, walk_end, hit_now, in_walk;

  logic                  net_we;
  logic [NAW-1:0]        net_waddr, net_raddr;
  logic [NET_WORD_W-1:0] net_wdata, net_rdata;
  logic                  asn_we;
  logic [AAW-1:0]        asn_waddr, asn_raddr;
  logic [31:0]           asn_rdata;
  logic                  code_we;
  logic [CAW-1:0]        code_waddr, code_raddr;
  logic [15:0]           code_rdata;

  logic          e_fam;
  logic [7:0]    e_pre, p6;
  logic [5:0]    p4;
  logic [127:0]  m128;
  logic [31:0]   m32;
  logic          net_hit;
  res_t          echo, plain;

  ipr_ram #(.WIDTH(NET_WORD_W), .DEPTH(NetDepth)) u_net_ram (
    .clk(clk), .we(net_we), .waddr(net_waddr), .wdata(net_wdata),
    .raddr(net_raddr), .rdata(net_rdata)
  );
  ipr_ram #(.WIDTH(32), .DEPTH(ASN_ENTRIES)) u_asn_ram (
    .clk(clk), .we(asn_we), .waddr(asn_waddr), .wdata(q_item.asn),
    .raddr(asn_raddr), .rdata(asn_rdata)
  );
  ipr_ram #(.WIDTH(16), .DEPTH(CodeDepth)) u_code_ram (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(q_item.cc),
    .raddr(code_raddr), .rdata(code_rdata)
  );

  // Counts above the table size saturate to it.
  assign n_allow = (int'(cfg.allow_net_count) > NET_ENTRIES) ? CW'(NET_ENTRIES)
                                                             : CW'(cfg.allow_net_count);
  assign n_block = (int'(cfg.block_net_count) > NET_ENTRIES) ? CW'(NET_ENTRIES)
                                                             : CW'(cfg.block_net_count);
  assign n_asn   = (int'(cfg.asn_count) > ASN_ENTRIES) ? CW'(ASN_ENTRIES)
                                                       : CW'(cfg.asn_count);
  assign n_flag  = (int'(cfg.flag_code_count) > CODE_ENTRIES) ? CW'(CODE_ENTRIES)
                                                              : CW'(cfg.flag_code_count);
  assign n_ac    = (int'(cfg.allow_code_count) > CODE_ENTRIES) ? CW'(CODE_ENTRIES)
                                                               : CW'(cfg.allow_code_count);
  assign n_bc    = (int'(cfg.block_code_count) > CODE_ENTRIES) ? CW'(CODE_ENTRIES)
                                                               : CW'(cfg.block_code_count);

  // Network entry compare on the registered read word.
  assign e_fam = net_rdata[136];
  assign e_pre = net_rdata[135:128];
  assign p6    = (e_pre > 8'd128) ? 8'd128 : e_pre;
  assign p4    = (e_pre > 8'd32) ? 6'd32 : e_pre[5:0];
  assign m128  = ~({128{1'b1}} >> p6);
  assign m32   = ~(32'hFFFF_FFFF >> p4);
  assign net_hit = (e_fam == cur.v6) &&
                   (cur.v6 ? ((({cur.hi, cur.lo} ^ net_rdata[127:0]) & m128) == 128'd0)
                           : (((cur.lo[31:0] ^ net_rdata[31:0]) & m32) == 32'd0));

  always_comb begin
    walk_cnt = '0;
    walk_hit = 1'b0;
    in_walk  = 1'b1;
    case (state)
      ST_ALLOW: begin walk_cnt = n_allow; walk_hit = net_hit; end
      ST_BLOCK: begin walk_cnt = n_block; walk_hit = net_hit; end
      ST_ASN: begin
        walk_cnt = (cur.asn != 32'd0) ? n_asn : '0;
        walk_hit = (asn_rdata == cur.asn);
      end
      ST_FLAG:  begin walk_cnt = n_flag; walk_hit = (code_rdata == cur.cc); end
      ST_ACODE: begin walk_cnt = n_ac;   walk_hit = (code_rdata == cur.cc); end
      ST_BCODE: begin walk_cnt = n_bc;   walk_hit = (code_rdata == cur.cc); end
      default:  in_walk = 1'b0;
    endcase
  end

  assign walk_end = (idx >= walk_cnt);
  assign hit_now  = cmpv && walk_hit;

  assign net_raddr  = NAW'(((state == ST_BLOCK) ? NET_ENTRIES : 0) + int'(idx));
  assign asn_raddr  = AAW'(idx);
  assign code_raddr = CAW'(((state == ST_ACODE) ? CODE_ENTRIES :
                            (state == ST_BCODE) ? 2 * CODE_ENTRIES : 0) + int'(idx));

  assign net_wdata  = {q_item.v6, q_item.prefix, q_item.hi, q_item.lo};
  assign net_waddr  = NAW'(((q_item.sel == TS_BLOCK_NET) ? NET_ENTRIES : 0) +
                           int'(q_item.idx));
  assign asn_waddr  = AAW'(q_item.idx);
  assign code_waddr = CAW'((int'(q_item.sel) - 3) * CODE_ENTRIES + int'(q_item.idx));

  // An item only starts once the result register is free or draining, so a
  // result can always be written when the walk finishes.
  assign q_pop = (state == ST_IDLE) && q_valid && (!res_valid || m_tready);

  always_comb begin
    plain = '0;
    echo  = '0;
    echo.geo_reached = 1'b1;
    echo.country_out = cur.cc;
    echo.flags_out   = cur.nf;
    echo.asn_out     = cur.asn;

    state_next = state;
    idx_next   = idx;
    cmpv_next  = cmpv;
    res_load   = 1'b0;
    res_next   = plain;
    net_we     = 1'b0;
    asn_we     = 1'b0;
    code_we    = 1'b0;

    if (in_walk) begin
      if (hit_now) begin
        cmpv_next = 1'b0;
        idx_next  = '0;
      end else if (!walk_end) begin
        idx_next  = idx + CW'(1);
        cmpv_next = 1'b1;
      end else begin
        idx_next  = '0;
        cmpv_next = 1'b0;
      end
    end

    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_item.op == OP_LOAD) begin
            net_we  = ((q_item.sel == TS_ALLOW_NET) || (q_item.sel == TS_BLOCK_NET)) &&
                      (int'(q_item.idx) < NET_ENTRIES);
            asn_we  = (q_item.sel == TS_ASN) && (int'(q_item.idx) < ASN_ENTRIES);
            code_we = ((q_item.sel == TS_FLAG_CODE) || (q_item.sel == TS_ALLOW_CODE) ||
                       (q_item.sel == TS_BLOCK_CODE)) && (int'(q_item.idx) < CODE_ENTRIES);
            res_load = 1'b1;
          end else begin
            state_next = ST_ALLOW;
            idx_next   = '0;
            cmpv_next  = 1'b0;
          end
        end
      end
      ST_ALLOW: begin
        if (hit_now) begin
          res_load = 1'b1;
          res_next.reason_code = R_ALLOWLIST;
          state_next = ST_IDLE;
        end else if (walk_end) begin
          state_next = ST_BLOCK;
        end
      end
      ST_BLOCK: begin
        if (hit_now) begin
          res_load = 1'b1;
          res_next.verdict     = V_FORBIDDEN;
          res_next.reason_code = R_BLOCKLIST;
          state_next = ST_IDLE;
        end else if (walk_end) begin
          state_next = ST_GEO;
        end
      end
      ST_GEO: begin
        idx_next  = '0;
        cmpv_next = 1'b0;
        if (!cfg.geo_enabled) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end else if (!cur.found) begin
          res_load = 1'b1;
          res_next.geo_reached = 1'b1;
          if (n_ac != '0) begin
            res_next.verdict     = V_HIDDEN;
            res_next.reason_code = R_NOT_WL;
          end
          state_next = ST_IDLE;
        end else if ((cur.nf & cfg.deny_flags) != 16'd0) begin
          res_load = 1'b1;
          res_next = echo;
          res_next.verdict     = V_FORBIDDEN;
          res_next.reason_code = R_FLAG;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_ASN;
        end
      end
      ST_ASN: begin
        if (hit_now) begin
          res_load = 1'b1;
          res_next = echo;
          res_next.verdict     = V_FORBIDDEN;
          res_next.reason_code = R_ASN;
          state_next = ST_IDLE;
        end else if (walk_end) begin
          state_next = ST_FLAG;
        end
      end
      ST_FLAG: begin
        if (hit_now) begin
          res_load = 1'b1;
          res_next = echo;
          res_next.verdict     = V_FORBIDDEN;
          res_next.reason_code = R_FLAG;
          state_next = ST_IDLE;
        end else if (walk_end) begin
          state_next = (n_ac != '0) ? ST_ACODE : ST_BCODE;
        end
      end
      ST_ACODE: begin
        if (hit_now) begin
          res_load   = 1'b1;
          res_next   = echo;
          state_next = ST_IDLE;
        end else if (walk_end) begin
          res_load = 1'b1;
          res_next = echo;
          res_next.verdict     = V_HIDDEN;
          res_next.reason_code = R_NOT_WL;
          state_next = ST_IDLE;
        end
      end
      ST_BCODE: begin
        if (hit_now) begin
          res_load = 1'b1;
          res_next = echo;
          res_next.verdict     = V_FORBIDDEN;
          res_next.reason_code = R_COUNTRY;
          state_next = ST_IDLE;
        end else if (walk_end) begin
          res_load   = 1'b1;
          res_next   = echo;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      cmpv      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cmpv  <= cmpv_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  a_hidden_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.verdict == V_HIDDEN) |-> (res.reason_code == R_NOT_WL))
    else $error("hidden verdict without the not-whitelisted reason");

  a_echo_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.geo_reached |->
      (res.country_out == 16'd0) && (res.flags_out == 16'd0) && (res.asn_out == 32'd0))
    else $error("geo echo set although the geo stage was not reached");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    q_pop && (q_item.op == OP_LOAD) |=>
      res_valid && (res.verdict == V_PASS) && (res.reason_code == R_NONE) &&
      !res.geo_reached)
    else $error("load transfer did not give an all-zero result");
endmodule

@@ rtl/core/ip_reputation_verdict_core.sv @@
// Address reputation verdict core: configuration registers, front end,
// decoupling queue and table walker. Depends on ipr_pkg, ipr_front,
// ipr_queue and ipr_back.
//
// Each input transfer either loads one table entry or checks one address and
// gives exactly one result transfer. A load passes through the queue and then
// the result register. A check walks the allow and block network lists and,
// with geo enabled, the ASN list and the country code lists one entry per cycle
// through the single read port of each table RAM; an early match ends the walk.
// Items are worked on one at a time, while a two-entry queue accepts input
// until it is full and the result register holds a finished result until it
// is taken. Configuration registers may only be written while the core is
// idle.
module ip_reputation_verdict_core #(
  parameter int NET_ENTRIES  = ipr_pkg::NET_ENTRIES_DEF,
  parameter int ASN_ENTRIES  = ipr_pkg::ASN_ENTRIES_DEF,
  parameter int CODE_ENTRIES = ipr_pkg::CODE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // is_ipv6, addr_high, addr_low, prefix_len, geo_found, country_code,
  // net_flags, asn, table_select, entry_index, zero padding
  input  logic [ipr_pkg::IN_TDATA_W-1:0]  s_tdata,
  // operation
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // verdict, reason_code, geo_reached, country_out, flags_out, asn_out,
  // zero padding
  output logic [ipr_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ipr_pkg::*;

  cfg_t  cfg;
  item_t f_item;
  item_t q_head;
  logic  q_full, q_valid, q_pop;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_ALLOW_NET_COUNT:  cfg.allow_net_count  <= cfg_wdata[4:0];
        CFG_BLOCK_NET_COUNT:  cfg.block_net_count  <= cfg_wdata[4:0];
        CFG_ASN_COUNT:        cfg.asn_count        <= cfg_wdata[4:0];
        CFG_FLAG_CODE_COUNT:  cfg.flag_code_count  <= cfg_wdata[5:0];
        CFG_ALLOW_CODE_COUNT: cfg.allow_code_count <= cfg_wdata[5:0];
        CFG_BLOCK_CODE_COUNT: cfg.block_code_count <= cfg_wdata[5:0];
        CFG_FLAG_MASK:        cfg.deny_flags       <= cfg_wdata;
        CFG_GEO_ENABLED:      cfg.geo_enabled      <= cfg_wdata[0];
        default:              cfg <= cfg;
      endcase
    end
  end

  ipr_front u_front (
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .item(f_item)
  );

  assign s_tready = !q_full;

  ipr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(s_tvalid && !q_full),
    .push_item(f_item),
    .full(q_full),
    .valid(q_valid),
    .pop(q_pop),
    .head(q_head)
  );

  ipr_back #(
    .NET_ENTRIES(NET_ENTRIES),
    .ASN_ENTRIES(ASN_ENTRIES),
    .CODE_ENTRIES(CODE_ENTRIES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_item(q_head),
    .q_pop(q_pop),
    .res_valid(m_tvalid),
    .res(res),
    .m_tready(m_tready)
  );

  assign m_tdata = {2'b00, res.asn_out, res.flags_out, res.country_out,
                    res.geo_reached, res.reason_code, res.verdict};
endmodule
